>>> rtl/fmpd_pkg.sv
package fmpd_pkg;

  // Number of CORDIC stages requested, and the length of the arctangent table
  localparam int CORDIC_STAGES  = 16;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int NSTG = (CORDIC_STAGES > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_STAGES;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int SUM_W    = PROD_W + 1;
  // |re|,|im| <= 2^31; the CORDIC gain (~1.65) times sqrt(2) stays below 2^33
  localparam int XY_W     = SUM_W + 3;
  localparam int ACC_W    = 32;
  localparam int PHASE_W  = 16;
  localparam int SHIFT_W  = $clog2(ATAN_TABLE_LEN);

  localparam logic [PHASE_W-1:0] PHASE_ZERO = '0;
  localparam logic [PHASE_W-1:0] PHASE_PI   = {1'b1, {(PHASE_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]   ACC_HALF   = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(1) << (ACC_W - PHASE_W - 1);

  // Payload handed from one CORDIC cell to the next
  typedef struct packed {
    logic                     valid;
    logic                     force_en;
    logic [PHASE_W-1:0]       force_val;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic [ACC_W-1:0]         acc;
  } cell_t;

  // atan(2^-k), 2^32 per full turn
  function automatic logic [ACC_W-1:0] atan_at(input logic [SHIFT_W-1:0] k);
    logic [ACC_W-1:0] v;
    unique case (k)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/fmpd_cordic_cell.sv
module fmpd_cordic_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic [fmpd_pkg::SHIFT_W-1:0]       shift,
  input  logic [fmpd_pkg::ACC_W-1:0]         atan,
  input  fmpd_pkg::cell_t                    d_in,
  output fmpd_pkg::cell_t                    d_out
);

  fmpd_pkg::cell_t              cell_r;
  fmpd_pkg::cell_t              cell_nxt;
  logic signed [fmpd_pkg::XY_W-1:0] dx;
  logic signed [fmpd_pkg::XY_W-1:0] dy;

  // arithmetic shift = floor shift
  assign dx = d_in.y >>> shift;
  assign dy = d_in.x >>> shift;

  always_comb begin
    cell_nxt = d_in;
    if (!d_in.y[fmpd_pkg::XY_W-1]) begin
      cell_nxt.x   = d_in.x + dx;
      cell_nxt.y   = d_in.y - dy;
      cell_nxt.acc = d_in.acc + atan;
    end else begin
      cell_nxt.x   = d_in.x - dx;
      cell_nxt.y   = d_in.y + dy;
      cell_nxt.acc = d_in.acc - atan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= d_in.valid;
    end
    if (en) begin
      cell_r.force_en  <= cell_nxt.force_en;
      cell_r.force_val <= cell_nxt.force_val;
      cell_r.x         <= cell_nxt.x;
      cell_r.y         <= cell_nxt.y;
      cell_r.acc       <= cell_nxt.acc;
    end
  end

  assign d_out = cell_r;

endmodule

>>> rtl/fm_polar_discriminator_core.sv
// Channel   Handshake             Payload
// in        in_valid / in_stall   in_i_sample, in_q_sample (s16 each)
// out       out_valid / out_stall out_phase_step (s16, pi/32768 units)
// cfg       psel/penable/pwrite   paddr[2:0], pwdata, prdata; reg 0 real_mode @ 0x0
//
// One request per cycle, sustained while out_stall does not hold the pipe. Registers in order:
// product, sum, pre-rotate, one per CORDIC cell, then the rounding register.
// Synchronous active-low reset clears the valid bits, have_last and real_mode.
// The whole pipe advances together; it holds only while a result sits in the
// output register and out_stall is high, and in_stall mirrors exactly that.
module fm_polar_discriminator_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [fmpd_pkg::SAMPLE_W-1:0]    in_i_sample,
  input  logic signed [fmpd_pkg::SAMPLE_W-1:0]    in_q_sample,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [fmpd_pkg::PHASE_W-1:0]     out_phase_step,
  // configuration
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [2:0]                              paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  localparam int NSTG = fmpd_pkg::NSTG;

  // ---------------------------------------------------------------- config
  logic real_mode_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, real_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      real_mode_r <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------- flow
  // Global advance: every stage moves when the output register can take data.
  logic adv;
  logic accept;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // ---------------------------------------------------------------- history
  logic signed [fmpd_pkg::SAMPLE_W-1:0] last_i_r;
  logic signed [fmpd_pkg::SAMPLE_W-1:0] last_q_r;
  logic                                 have_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_last_r <= 1'b0;
      last_i_r    <= '0;
      last_q_r    <= '0;
    end else if (accept) begin
      have_last_r <= 1'b1;
      last_i_r    <= in_i_sample;
      last_q_r    <= in_q_sample;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // conj(prev) * cur: four exact 16x16 products
  logic                                 s1_valid_r;
  logic                                 s1_first_r;
  logic                                 s1_real_r;
  logic signed [fmpd_pkg::PROD_W-1:0]   s1_ii_r;
  logic signed [fmpd_pkg::PROD_W-1:0]   s1_qq_r;
  logic signed [fmpd_pkg::PROD_W-1:0]   s1_iq_r;
  logic signed [fmpd_pkg::PROD_W-1:0]   s1_qi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
    if (adv) begin
      s1_first_r <= !have_last_r;
      s1_real_r  <= real_mode_r;
      s1_ii_r    <= last_i_r * in_i_sample;
      s1_qq_r    <= last_q_r * in_q_sample;
      s1_iq_r    <= last_i_r * in_q_sample;
      s1_qi_r    <= last_q_r * in_i_sample;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // re/im sums; first sample and real mode settle their answer here
  logic                                 s2_valid_r;
  logic                                 s2_force_r;
  logic [fmpd_pkg::PHASE_W-1:0]         s2_fval_r;
  logic signed [fmpd_pkg::SUM_W-1:0]    s2_re_r;
  logic signed [fmpd_pkg::SUM_W-1:0]    s2_im_r;
  logic                                 s2_force_nxt;
  logic [fmpd_pkg::PHASE_W-1:0]         s2_fval_nxt;

  always_comb begin
    s2_force_nxt = 1'b0;
    s2_fval_nxt  = fmpd_pkg::PHASE_ZERO;
    priority if (s1_first_r) begin
      s2_force_nxt = 1'b1;
    end else if (s1_real_r) begin
      // only the sign of prev*cur counts; the exact product sign is bit 31
      s2_force_nxt = 1'b1;
      s2_fval_nxt  = s1_ii_r[fmpd_pkg::PROD_W-1] ? fmpd_pkg::PHASE_PI : fmpd_pkg::PHASE_ZERO;
    end else begin
      s2_force_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
    if (adv) begin
      s2_force_r <= s2_force_nxt;
      s2_fval_r  <= s2_fval_nxt;
      s2_re_r    <= fmpd_pkg::SUM_W'(s1_ii_r) + fmpd_pkg::SUM_W'(s1_qq_r);
      s2_im_r    <= fmpd_pkg::SUM_W'(s1_iq_r) - fmpd_pkg::SUM_W'(s1_qi_r);
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Zero and purely real products bypass the CORDIC; left half plane is
  // turned by pi up front.
  fmpd_pkg::cell_t                      pre_r;
  fmpd_pkg::cell_t                      pre_nxt;
  logic signed [fmpd_pkg::XY_W-1:0]     re_ext;
  logic signed [fmpd_pkg::XY_W-1:0]     im_ext;

  assign re_ext = fmpd_pkg::XY_W'(s2_re_r);
  assign im_ext = fmpd_pkg::XY_W'(s2_im_r);

  always_comb begin
    pre_nxt.valid     = s2_valid_r;
    pre_nxt.force_en  = s2_force_r;
    pre_nxt.force_val = s2_fval_r;
    pre_nxt.x         = re_ext;
    pre_nxt.y         = im_ext;
    pre_nxt.acc       = '0;
    if (!s2_force_r) begin
      if (s2_im_r == '0) begin
        pre_nxt.force_en  = 1'b1;
        pre_nxt.force_val = s2_re_r[fmpd_pkg::SUM_W-1] ? fmpd_pkg::PHASE_PI
                                                       : fmpd_pkg::PHASE_ZERO;
      end else if (s2_re_r[fmpd_pkg::SUM_W-1]) begin
        pre_nxt.x   = -re_ext;
        pre_nxt.y   = -im_ext;
        pre_nxt.acc = fmpd_pkg::ACC_HALF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r.valid <= 1'b0;
    end else if (adv) begin
      pre_r.valid <= pre_nxt.valid;
    end
    if (adv) begin
      pre_r.force_en  <= pre_nxt.force_en;
      pre_r.force_val <= pre_nxt.force_val;
      pre_r.x         <= pre_nxt.x;
      pre_r.y         <= pre_nxt.y;
      pre_r.acc       <= pre_nxt.acc;
    end
  end

  // ---------------------------------------------------------------- CORDIC row
  fmpd_pkg::cell_t chain [0:NSTG];

  assign chain[0] = pre_r;

  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    fmpd_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .shift (fmpd_pkg::SHIFT_W'(g)),
      .atan  (fmpd_pkg::atan_at(fmpd_pkg::SHIFT_W'(g))),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  // ---------------------------------------------------------------- output
  // Round the turn accumulator to 16 bits; wraps modulo 2^16.
  logic                          out_valid_r;
  logic [fmpd_pkg::PHASE_W-1:0]  phase_r;
  logic [fmpd_pkg::ACC_W-1:0]    acc_rnd;

  assign acc_rnd = chain[NSTG].acc + fmpd_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[NSTG].valid;
    end
    if (adv) begin
      phase_r <= chain[NSTG].force_en ? chain[NSTG].force_val
                                      : acc_rnd[fmpd_pkg::ACC_W-1 -: fmpd_pkg::PHASE_W];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_phase_step = $signed(phase_r);

endmodule
